@@ rtl/core/double_add_mul_div_unit_macros.svh @@
// Assertion macros for the binary64 add/mul/div unit.
`ifndef DOUBLE_ADD_MUL_DIV_UNIT_MACROS_SVH
`define DOUBLE_ADD_MUL_DIV_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DADMD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DADMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/dadmd_pkg.sv @@
// Shared types and constants for the binary64 add/mul/div unit.
package dadmd_pkg;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_MUL = 2'd1;
	localparam logic [1:0] MODE_DIV = 2'd2;

	localparam int EXP_W = 14;
	localparam logic [10:0] EXP_ALL = 11'h7FF;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [6:0] DIV_LAST = 7'd64;
	localparam logic [6:0] MUL_LAST = 7'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ALIGN,
		ST_SUM,
		ST_MUL,
		ST_DNORM,
		ST_DIV,
		ST_NORM,
		ST_PACK
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic add_align;
		logic add_sum;
		logic mul_step;
		logic dnorm_step;
		logic div_step;
		logic norm_step;
		logic pack;
	} dadmd_cmd_t;

	typedef struct packed {
		logic       special;
		logic [1:0] mode;
		logic       mul_last;
		logic       dnorm_done;
		logic       div_last;
		logic       norm_done;
	} dadmd_sts_t;

endpackage

@@ rtl/core/dadmd_datapath.sv @@
// Datapath: operand decode, align/add, multiply, divide, normalize and pack.
module dadmd_datapath import dadmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dadmd_cmd_t  cmd,
	input  logic [1:0]  mode,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output dadmd_sts_t  sts,
	output logic [63:0] result_bits
);

	logic [1:0]  mode_q;
	logic [63:0] a_q, b_q;
	logic        spec_q;
	logic [63:0] spec_res_q;
	logic        sign_q, sx_q, sy_q;
	logic [52:0] ma_q, mb_q, rem_q;
	logic signed [EXP_W-1:0] ea_q, eb_q, t_q;
	logic [127:0] yal_q, acc_q;
	logic        st_q;
	logic [6:0]  cnt_q;
	logic [63:0] result_q;

	// operand decode
	logic [10:0] fa, fb;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, neg, swap;
	logic [52:0] sig_a, sig_b;
	logic signed [EXP_W-1:0] ue_a, ue_b;
	logic        spec;
	logic [63:0] spec_res;

	assign fa = a_q[62:52];
	assign fb = b_q[62:52];
	assign nan_a = (fa == EXP_ALL) && (a_q[51:0] != 52'd0);
	assign nan_b = (fb == EXP_ALL) && (b_q[51:0] != 52'd0);
	assign inf_a = (fa == EXP_ALL) && (a_q[51:0] == 52'd0);
	assign inf_b = (fb == EXP_ALL) && (b_q[51:0] == 52'd0);
	assign zero_a = (a_q[62:0] == 63'd0);
	assign zero_b = (b_q[62:0] == 63'd0);
	assign neg = a_q[63] ^ b_q[63];
	assign sig_a = {fa != 11'd0, a_q[51:0]};
	assign sig_b = {fb != 11'd0, b_q[51:0]};
	assign ue_a = signed'({3'b0, (fa != 11'd0) ? fa : 11'd1}) - 14'sd1075;
	assign ue_b = signed'({3'b0, (fb != 11'd0) ? fb : 11'd1}) - 14'sd1075;
	assign swap = (mode_q == MODE_ADD) && (ue_a < ue_b);

	always_comb begin
		spec = 1'b1;
		spec_res = ALL_ONES;
		unique case (mode_q)
			MODE_ADD: begin
				if (nan_a || nan_b) spec_res = ALL_ONES;
				else if (inf_a && inf_b) spec_res = (a_q[63] ^ b_q[63]) ? ALL_ONES : a_q;
				else if (inf_a) spec_res = a_q;
				else if (inf_b) spec_res = b_q;
				else if (zero_a && zero_b) spec_res = {a_q[63] & b_q[63], 63'd0};
				else spec = 1'b0;
			end
			MODE_MUL: begin
				if (nan_a) spec_res = a_q;
				else if (nan_b) spec_res = b_q;
				else if ((inf_a && zero_b) || (inf_b && zero_a))
					spec_res = ALL_ONES ^ {neg, 63'd0};
				else if (inf_a || inf_b) spec_res = {neg, EXP_ALL, 52'd0};
				else if (zero_a || zero_b) spec_res = {neg, 63'd0};
				else spec = 1'b0;
			end
			MODE_DIV: begin
				if (nan_a) spec_res = a_q;
				else if (nan_b) spec_res = b_q;
				else if (zero_b)
					spec_res = zero_a ? (ALL_ONES ^ {neg, 63'd0}) : {neg, EXP_ALL, 52'd0};
				else if (inf_a)
					spec_res = inf_b ? (ALL_ONES ^ {neg, 63'd0}) : {neg, EXP_ALL, 52'd0};
				else if (zero_a || inf_b) spec_res = {neg, 63'd0};
				else spec = 1'b0;
			end
			default: begin
				spec_res = ALL_ONES;
			end
		endcase
	end

	// alignment shift and sticky
	logic signed [EXP_W-1:0] d;
	logic         big;
	logic [127:0] yal;
	logic [63:0]  lmask;
	logic         st;

	assign d = ea_q - eb_q;
	assign big = (d[EXP_W-1:7] != '0);
	assign yal = big ? 128'd0 : ({11'd0, mb_q, 64'd0} >> d[6:0]);
	assign lmask = (64'd1 << d[5:0]) - 64'd1;
	always_comb begin
		if (big) st = |mb_q;
		else if (d > 14'sd64) st = |({11'd0, mb_q} & lmask);
		else st = 1'b0;
	end

	// add / subtract
	logic [127:0] xal;
	logic [128:0] diff;
	assign xal = {11'd0, ma_q, 64'd0};
	assign diff = {1'b0, xal} - {1'b0, yal_q} - {128'd0, st_q};

	// multiply partial product
	logic [31:0]  pa, pb;
	logic [63:0]  prod;
	logic [127:0] pp;
	logic [1:0]   pos;
	assign pa = cnt_q[0] ? {11'd0, ma_q[52:32]} : ma_q[31:0];
	assign pb = cnt_q[1] ? {11'd0, mb_q[52:32]} : mb_q[31:0];
	assign prod = pa * pb;
	assign pos = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
	always_comb begin
		case (pos)
			2'd0: pp = {64'd0, prod};
			2'd1: pp = {32'd0, prod, 32'd0};
			default: pp = {prod, 64'd0};
		endcase
	end

	// divide step
	logic [53:0] cand;
	logic        ge;
	logic [53:0] rsub;
	assign cand = (cnt_q == 7'd0) ? {1'b0, ma_q} : {rem_q, 1'b0};
	assign ge = cand >= {1'b0, mb_q};
	assign rsub = cand - {1'b0, mb_q};

	// pack
	logic signed [EXP_W-1:0] tb, sh;
	logic [127:0] den;
	logic [63:0]  pk;
	assign tb = t_q + 14'sd1023;
	assign sh = -14'sd947 - t_q;
	assign den = acc_q >> sh[6:0];
	always_comb begin
		if (spec_q) pk = spec_res_q;
		else if (acc_q == 128'd0) pk = {sign_q, 63'd0};
		else if (t_q > 14'sd1023) pk = {sign_q, EXP_ALL, 52'd0};
		else if (t_q >= -14'sd1022) pk = {sign_q, tb[10:0], acc_q[126:75]};
		else if (sh > 14'sd127) pk = {sign_q, 63'd0};
		else pk = {sign_q, den[62:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.setup) begin
			cnt_q <= '0;
		end else if (cmd.mul_step || cmd.div_step) begin
			cnt_q <= cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			a_q <= operand_a;
			b_q <= operand_b;
		end
		if (cmd.setup) begin
			spec_q <= spec;
			spec_res_q <= spec_res;
			acc_q <= '0;
			sign_q <= neg;
			ma_q <= swap ? sig_b : sig_a;
			mb_q <= swap ? sig_a : sig_b;
			ea_q <= swap ? ue_b : ue_a;
			eb_q <= swap ? ue_a : ue_b;
			sx_q <= swap ? b_q[63] : a_q[63];
			sy_q <= swap ? a_q[63] : b_q[63];
			t_q <= ue_a + ue_b + 14'sd127;
		end
		if (cmd.add_align) begin
			yal_q <= yal;
			st_q <= st;
			t_q <= ea_q + 14'sd63;
		end
		if (cmd.add_sum) begin
			if (sx_q == sy_q) begin
				acc_q <= xal + yal_q;
				sign_q <= sx_q;
			end else if (diff[128]) begin
				acc_q <= ~diff[127:0] + 128'd1;
				sign_q <= sy_q;
			end else begin
				acc_q <= diff[127:0];
				sign_q <= (diff[127:0] == 128'd0) ? 1'b0 : sx_q;
			end
		end
		if (cmd.mul_step) begin
			acc_q <= acc_q + pp;
		end
		if (cmd.dnorm_step) begin
			if (!ma_q[52]) begin
				if (ma_q[52:45] == 8'd0) begin
					ma_q <= ma_q << 8;
					ea_q <= ea_q - 14'sd8;
				end else begin
					ma_q <= ma_q << 1;
					ea_q <= ea_q - 14'sd1;
				end
			end
			if (!mb_q[52]) begin
				if (mb_q[52:45] == 8'd0) begin
					mb_q <= mb_q << 8;
					eb_q <= eb_q - 14'sd8;
				end else begin
					mb_q <= mb_q << 1;
					eb_q <= eb_q - 14'sd1;
				end
			end
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rsub[52:0] : cand[52:0];
			acc_q <= {acc_q[126:0], ge};
			if (cnt_q == 7'd0) t_q <= ea_q - eb_q + 14'sd63;
		end
		if (cmd.norm_step) begin
			if (acc_q[127:96] == 32'd0) begin
				acc_q <= acc_q << 32;
				t_q <= t_q - 14'sd32;
			end else if (acc_q[127:120] == 8'd0) begin
				acc_q <= acc_q << 8;
				t_q <= t_q - 14'sd8;
			end else if (!acc_q[127]) begin
				acc_q <= acc_q << 1;
				t_q <= t_q - 14'sd1;
			end
		end
		if (cmd.pack) begin
			result_q <= pk;
		end
	end

	assign sts.special = spec;
	assign sts.mode = mode_q;
	assign sts.mul_last = (cnt_q == MUL_LAST);
	assign sts.dnorm_done = ma_q[52] && mb_q[52];
	assign sts.div_last = (cnt_q == DIV_LAST);
	assign sts.norm_done = acc_q[127] || (acc_q == 128'd0);
	assign result_bits = result_q;

endmodule

@@ rtl/core/dadmd_ctrl.sv @@
// Controller state machine: sequences the datapath and owns the handshakes.
module dadmd_ctrl import dadmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dadmd_sts_t sts,
	output dadmd_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				if (sts.special) state_d = ST_PACK;
				else begin
					unique case (sts.mode)
						MODE_ADD: state_d = ST_ALIGN;
						MODE_MUL: state_d = ST_MUL;
						default:  state_d = ST_DNORM;
					endcase
				end
			end
			ST_ALIGN: begin
				cmd.add_align = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.add_sum = 1'b1;
				state_d = ST_NORM;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_d = ST_NORM;
			end
			ST_DNORM: begin
				if (sts.dnorm_done) state_d = ST_DIV;
				else cmd.dnorm_step = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (sts.norm_done) state_d = ST_PACK;
				else cmd.norm_step = 1'b1;
			end
			ST_PACK: begin
				if (!out_valid_q || !out_stall) begin
					cmd.pack = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.pack) out_valid_d = 1'b1;
		else if (out_valid_q && !out_stall) out_valid_d = 1'b0;
		else out_valid_d = out_valid_q;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/double_add_mul_div_unit.sv @@
// Top level of the binary64 add/multiply/divide unit with truncation toward zero.
// One transaction at a time: operands are taken when the unit is idle and the result
// sits in an output register, so a new transaction may start while it waits. NaN,
// infinity and zero cases go straight to packing. Multiply sums four 32x32 partial
// products, one per cycle; divide uses a restoring divider at one quotient bit per
// cycle over 65 bits, after subnormal pre-normalization of the operands. The final
// normalizer shifts by 32, 8 or 1 bit a cycle. Mode 3 returns the all-ones NaN.
module double_add_mul_div_unit import dadmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_bits
);

`include "double_add_mul_div_unit_macros.svh"

	dadmd_cmd_t cmd;
	dadmd_sts_t sts;

	dadmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dadmd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.sts         (sts),
		.result_bits (result_bits)
	);

	`DADMD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept not followed by busy")
	`DADMD_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0(cmd), "datapath commands overlap")
	`DADMD_ASSERT_NEXT(a_pack_gives_valid, cmd.pack, out_valid, "packed result not presented")

endmodule

@@ dv/double_add_mul_div_unit_tb.sv @@
// Testbench for double_add_mul_div_unit: directed and random transactions checked against a binary64 predictor.
module double_add_mul_div_unit_tb;
	import dadmd_pkg::*;

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0] HIDDEN = 64'h0010_0000_0000_0000;
	localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int N_RANDOM = 700;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] a;
		logic [63:0] b;
	} fp_txn_t;

	class fp_scoreboard;
		logic [63:0] expected_q[$];
		int fails;

		function new();
			fails = 0;
		endfunction

		static function logic [10:0] fexp(logic [63:0] x);
			return x[62:52];
		endfunction

		static function bit is_nan(logic [63:0] x);
			return fexp(x) == EXP_ALL && (x & FRAC_MASK) != 0;
		endfunction

		static function bit is_inf(logic [63:0] x);
			return fexp(x) == EXP_ALL && (x & FRAC_MASK) == 0;
		endfunction

		static function bit is_zero(logic [63:0] x);
			return x[62:0] == 0;
		endfunction

		static function logic [63:0] signif(logic [63:0] x);
			return (x & FRAC_MASK) | (fexp(x) != 0 ? HIDDEN : 64'd0);
		endfunction

		static function int uexp(logic [63:0] x);
			int f;
			f = fexp(x);
			return (f != 0 ? f : 1) - 1075;
		endfunction

		// sign | trunc(m * 2^e)
		static function logic [63:0] pack_fp(logic [63:0] sgn, logic [127:0] m, int e);
			int p, t, s, sh;
			logic [63:0] v;
			if (m == 0)
				return sgn;
			p = 127;
			while (p > 0 && !m[p])
				p--;
			t = e + p;
			if (t > 1023)
				return sgn | INF_BITS;
			if (t >= -1022) begin
				sh = p - 52;
				v = sh >= 0 ? 64'(m >> sh) : (m[63:0] << (-sh));
				return sgn | (64'(t + 1023) << 52) | (v & FRAC_MASK);
			end
			s = e + 1074;
			if (s >= 0)
				return sgn | (m[63:0] << s);
			if (-s >= 128)
				return sgn;
			return sgn | 64'(m >> (-s));
		endfunction

		static function logic [63:0] fp_add(logic [63:0] a_in, logic [63:0] b_in);
			logic [63:0] a, b, sx, sy, mx, my, sgn;
			logic [127:0] x, y, m, mask;
			int ex, ey, d;
			bit st;
			a = a_in;
			b = b_in;
			if (is_nan(a) || is_nan(b))
				return ALL_ONES;
			if (is_inf(a) && is_inf(b))
				return ((a ^ b) & SIGN_BIT) != 0 ? ALL_ONES : a;
			if (is_inf(a))
				return a;
			if (is_inf(b))
				return b;
			if (is_zero(a) && is_zero(b))
				return (a & b & SIGN_BIT);
			if (uexp(a) < uexp(b)) begin
				a = b_in;
				b = a_in;
			end
			sx = a & SIGN_BIT;
			sy = b & SIGN_BIT;
			mx = signif(a);
			my = signif(b);
			ex = uexp(a);
			ey = uexp(b);
			d = ex - ey;
			x = {mx, 64'd0};
			y = {my, 64'd0};
			if (d >= 128) begin
				st = y != 0;
				y = 0;
			end else begin
				mask = (128'd1 << d) - 1;
				st = (y & mask) != 0;
				y = y >> d;
			end
			if (sx == sy) begin
				m = x + y;
				sgn = sx;
			end else if (d == 0) begin
				if (mx == my)
					return 64'd0;
				if (mx > my) begin
					m = {mx - my, 64'd0};
					sgn = sx;
				end else begin
					m = {my - mx, 64'd0};
					sgn = sy;
				end
			end else begin
				m = x - y;
				if (st)
					m = m - 1;
				sgn = sx;
			end
			return pack_fp(sgn, m, ex - 64);
		endfunction

		static function logic [63:0] fp_mul(logic [63:0] a, logic [63:0] b);
			logic [63:0] neg;
			logic [127:0] prod;
			if (is_nan(a))
				return a;
			if (is_nan(b))
				return b;
			neg = (a ^ b) & SIGN_BIT;
			if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a)))
				return ALL_ONES ^ neg;
			if (is_inf(a) || is_inf(b))
				return INF_BITS | neg;
			if (is_zero(a) || is_zero(b))
				return neg;
			prod = {64'd0, signif(a)} * {64'd0, signif(b)};
			return pack_fp(neg, prod, uexp(a) + uexp(b));
		endfunction

		static function logic [63:0] fp_div(logic [63:0] a, logic [63:0] b);
			logic [63:0] neg, ma, mb;
			logic [127:0] q;
			int ea, eb;
			if (is_nan(a))
				return a;
			if (is_nan(b))
				return b;
			neg = (a ^ b) & SIGN_BIT;
			if (is_zero(b))
				return is_zero(a) ? (ALL_ONES ^ neg) : (INF_BITS | neg);
			if (is_inf(a))
				return is_inf(b) ? (ALL_ONES ^ neg) : (INF_BITS | neg);
			if (is_zero(a) || is_inf(b))
				return neg;
			ma = signif(a);
			mb = signif(b);
			ea = uexp(a);
			eb = uexp(b);
			while ((ma & HIDDEN) == 0) begin
				ma = ma << 1;
				ea--;
			end
			while ((mb & HIDDEN) == 0) begin
				mb = mb << 1;
				eb--;
			end
			q = {ma, 64'd0} / {64'd0, mb};
			return pack_fp(neg, q, ea - eb - 64);
		endfunction

		static function logic [63:0] fp_result(logic [1:0] op, logic [63:0] a, logic [63:0] b);
			case (op)
				MODE_ADD: return fp_add(a, b);
				MODE_MUL: return fp_mul(a, b);
				MODE_DIV: return fp_div(a, b);
				default:  return ALL_ONES;
			endcase
		endfunction

		function void note_input(logic [1:0] op, logic [63:0] a, logic [63:0] b);
			expected_q.push_back(fp_result(op, a, b));
		endfunction

		function void check_result(logic [63:0] r);
			logic [63:0] exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result_bits %h", $time, r);
				fails++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (r !== exp_r) begin
				$display("%0t: result_bits mismatch: expected %h actual %h", $time, exp_r, r);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_ADD;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] result_bits;

	fp_scoreboard sb = new();
	int idle_cycles = 0;

	double_add_mul_div_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_bits(result_bits)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [63:0] rand_operand();
		logic [63:0] x;
		x = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1: ;
			2: begin
				case ($urandom_range(0, 4))
					0: x[62:0] = '0;
					1: x[62:0] = {11'h7FF, 52'd0};
					2: x[62:52] = 11'h7FF;
					3: x[62:0] = 63'h7FEF_FFFF_FFFF_FFFF;
					default: x[62:0] = 63'd1;
				endcase
			end
			3: x[62:52] = 11'd0;
			4: x[62:52] = 11'd2046 - 11'($urandom_range(0, 3));
			5: x[62:52] = 11'($urandom_range(1, 4));
			default: x[62:52] = 11'($urandom_range(960, 1090));
		endcase
		if (x[62:52] == 11'h7FF && $urandom_range(0, 2) != 0)
			x[62:52] = 11'h7FE;
		return x;
	endfunction

	task automatic send(logic [1:0] op, logic [63:0] a, logic [63:0] b);
		int g;
		in_valid <= 1'b1;
		mode <= op;
		operand_a <= a;
		operand_b <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(op, a, b);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_bits);
	end

	initial begin
		int n;
		@(posedge clk);
		wait (arst_n);
		forever begin
			n = gap_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("double_add_mul_div_unit_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		fp_txn_t directed[$];
		logic [1:0] op;
		logic [63:0] a, b;
		directed = '{
			'{MODE_ADD, 64'h7FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000},
			'{MODE_ADD, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000},
			'{MODE_ADD, 64'hFFF0_0000_0000_0000, 64'hFFF0_0000_0000_0000},
			'{MODE_ADD, 64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000},
			'{MODE_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000},
			'{MODE_ADD, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000},
			'{MODE_ADD, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000},
			'{MODE_ADD, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF},
			'{MODE_ADD, 64'h3FF0_0000_0000_0000, 64'hBC30_0000_0000_0001},
			'{MODE_ADD, 64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF},
			'{MODE_MUL, 64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0001},
			'{MODE_MUL, 64'h7FF0_0000_0000_0002, 64'h7FF8_0000_0000_0000},
			'{MODE_MUL, 64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0000},
			'{MODE_MUL, 64'h7FF0_0000_0000_0000, 64'h0000_0000_0000_0000},
			'{MODE_MUL, 64'h7FF0_0000_0000_0000, 64'hC000_0000_0000_0000},
			'{MODE_MUL, 64'h0000_0000_0000_0000, 64'hC008_0000_0000_0000},
			'{MODE_MUL, 64'h7FEF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000},
			'{MODE_MUL, 64'h8000_0000_0000_0001, 64'h3FE0_0000_0000_0000},
			'{MODE_MUL, 64'h4008_0000_0000_0000, 64'h3FD5_5555_5555_5555},
			'{MODE_DIV, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000},
			'{MODE_DIV, 64'hBFF0_0000_0000_0000, 64'h0000_0000_0000_0000},
			'{MODE_DIV, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000},
			'{MODE_DIV, 64'h7FF0_0000_0000_0000, 64'h4000_0000_0000_0000},
			'{MODE_DIV, 64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000},
			'{MODE_DIV, 64'h3FF0_0000_0000_0000, 64'h4008_0000_0000_0000},
			'{MODE_DIV, 64'h0000_0000_0000_0003, 64'h7FEF_FFFF_FFFF_FFFF},
			'{MODE_DIV, 64'h7FEF_FFFF_FFFF_FFFF, 64'h000F_FFFF_FFFF_FFFF},
			'{MODE_NONE, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send(directed[i].op, directed[i].a, directed[i].b);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				wait (sb.expected_q.size() == 0);
				@(posedge clk);
			end
			op = $urandom_range(0, 19) == 0 ? MODE_NONE : 2'($urandom_range(0, 2));
			a = rand_operand();
			b = rand_operand();
			if (op == MODE_ADD && $urandom_range(0, 3) == 0) begin
				b = a ^ SIGN_BIT;
				b[19:0] = 20'($urandom);
				if ($urandom_range(0, 1) == 0)
					b[62:52] = b[62:52] - 11'($urandom_range(0, 2));
			end
			send(op, a, b);
		end
		in_valid <= 1'b0;
		wait (sb.expected_q.size() == 0);
		repeat (150) @(posedge clk);
		if (sb.fails == 0)
			$display("double_add_mul_div_unit_tb OK");
		else
			$display("double_add_mul_div_unit_tb NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/dadmd_pkg.sv
rtl/core/dadmd_datapath.sv
rtl/core/dadmd_ctrl.sv
rtl/core/double_add_mul_div_unit.sv
dv/double_add_mul_div_unit_tb.sv
